// ----- src/rspe_pkg.sv -----
// Shared types and constants for the Reed-Solomon parity encoder.
// Holds register map, field widths and the cell control encoding; no dependencies.
package rspe_pkg;

    // Configuration register map (index = byte address / 4)
    localparam int          ADDR_W          = 4;
    localparam logic [1:0]  REG_FIELD_POLY  = 2'd0;
    localparam logic [1:0]  REG_GEN_BASE    = 2'd1;
    localparam logic [1:0]  REG_EC_COUNT    = 2'd2;

    localparam int          FIELD_POLY_W    = 9;
    localparam int          GEN_BASE_W      = 8;
    localparam int          EC_COUNT_W      = 5;

    localparam logic [FIELD_POLY_W-1:0] FIELD_POLY_RST = 9'd285;
    localparam logic [GEN_BASE_W-1:0]   GEN_BASE_RST   = 8'd0;
    localparam logic [EC_COUNT_W-1:0]   EC_COUNT_RST   = 5'd10;

    // Cell operations
    localparam logic [2:0]  CELL_HOLD  = 3'd0;
    localparam logic [2:0]  CELL_CLEAR = 3'd1;
    localparam logic [2:0]  CELL_BUILD = 3'd2;
    localparam logic [2:0]  CELL_STEP  = 3'd3;
    localparam logic [2:0]  CELL_SHIFT = 3'd4;

    typedef struct packed {
        logic [2:0] op;
    } cell_ctrl_t;

endpackage

// ----- src/rspe_data_if.sv -----
// Input channel of the parity encoder: one data symbol per transaction.
// Valid/ready handshake; no dependencies.
interface rspe_data_if #(
    parameter int SYMBOL_BITS = 8
) ();
    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] data_symbol;
    logic                   last_data;

    modport source (output valid, output data_symbol, output last_data, input ready);
    modport sink   (input valid, input data_symbol, input last_data, output ready);
endinterface

// ----- src/rspe_parity_if.sv -----
// Output channel of the parity encoder: one parity symbol per transaction.
// Valid/ready handshake; no dependencies.
interface rspe_parity_if #(
    parameter int SYMBOL_BITS = 8
) ();
    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] parity_symbol;
    logic                   last_parity;

    modport source (output valid, output parity_symbol, output last_parity, input ready);
    modport sink   (input valid, input parity_symbol, input last_parity, output ready);
endinterface

// ----- src/reed_solomon_parity_encoder.sv -----
// Systematic Reed-Solomon parity encoder over GF(2^SYMBOL_BITS), top level.
// Depends on rspe_pkg, rspe_data_if, rspe_parity_if and rspe_cell.
//
// Usage:
//   data_in carries one message symbol per transaction, highest coefficient first,
//   with last_data on the final symbol of a codeword. parity_out then carries the
//   n parity symbols (n = ec_count clipped to 1..MAX_EC), highest first, with
//   last_parity on the final one. Data symbols are not echoed.
//   Configuration is by APB writes: field_poly at 0x0, gen_base at 0x4, ec_count
//   at 0x8. Any write to one of these registers restarts the generator build and clears the parity registers.
// Timing:
//   After reset or a write the cell chain builds the generator; data_in.ready
//   stays low meanwhile. Data symbols stream through the chain of cells at one per
//   cycle while data_in.ready is high. After the last symbol the chain shifts its
//   parity out, one symbol per parity_out transaction. The first parity symbol is
//   valid the cycle after the last data. While parity_out is stalled the chain
//   holds and data_in.ready stays low.
// Reset:
//   rst_n clears the configuration registers to their defaults and zeroes the parity registers.
module reed_solomon_parity_encoder #(
    parameter int MAX_EC      = 30,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rspe_data_if.sink                         data_in,
    rspe_parity_if.source                     parity_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rspe_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int NW    = $clog2(MAX_EC + 1);
    localparam int EXW   = (NW > rspe_pkg::EC_COUNT_W) ? NW : rspe_pkg::EC_COUNT_W;
    localparam int CNT_W = (NW > rspe_pkg::GEN_BASE_W) ? NW : rspe_pkg::GEN_BASE_W;
    localparam int FPX_W = (SYMBOL_BITS > rspe_pkg::FIELD_POLY_W) ?
                           SYMBOL_BITS : rspe_pkg::FIELD_POLY_W;
    localparam int SW    = SYMBOL_BITS;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_ROOT = 3'd1;
    localparam logic [2:0] ST_POLY = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [rspe_pkg::FIELD_POLY_W-1:0] field_poly_reg;
    logic [rspe_pkg::GEN_BASE_W-1:0]   gen_base_reg;
    logic [rspe_pkg::EC_COUNT_W-1:0]   ec_count_reg;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]    root_reg, root_next;

    logic             cfg_wr;
    logic             cfg_hit;
    logic [FPX_W-1:0] fp_ext;
    logic [SW-1:0]    fb;
    logic [SW-1:0]    root_x2;
    logic [EXW-1:0]   ec_ext;
    logic [NW-1:0]    n_act;
    logic [CNT_W-1:0] n_last;
    logic [SW-1:0]    fbk;
    logic [SW-1:0]    bcast;
    logic             in_acc;
    logic             out_acc;
    logic             emit_last;

    rspe_pkg::cell_ctrl_t ctrl;

    logic [SW-1:0] h_w [MAX_EC];
    logic [SW-1:0] q_w [MAX_EC];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && ((paddr[3:2] == rspe_pkg::REG_FIELD_POLY) ||
                                (paddr[3:2] == rspe_pkg::REG_GEN_BASE) ||
                                (paddr[3:2] == rspe_pkg::REG_EC_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_poly_reg <= rspe_pkg::FIELD_POLY_RST;
            gen_base_reg   <= rspe_pkg::GEN_BASE_RST;
            ec_count_reg   <= rspe_pkg::EC_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                rspe_pkg::REG_FIELD_POLY: field_poly_reg <= pwdata[rspe_pkg::FIELD_POLY_W-1:0];
                rspe_pkg::REG_GEN_BASE:   gen_base_reg   <= pwdata[rspe_pkg::GEN_BASE_W-1:0];
                rspe_pkg::REG_EC_COUNT:   ec_count_reg   <= pwdata[rspe_pkg::EC_COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            rspe_pkg::REG_FIELD_POLY: prdata = 32'(field_poly_reg);
            rspe_pkg::REG_GEN_BASE:   prdata = 32'(gen_base_reg);
            rspe_pkg::REG_EC_COUNT:   prdata = 32'(ec_count_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- derived settings ----------------
    // Top bit of the polynomial is implied; only the low symbol bits feed back
    assign fp_ext  = FPX_W'(field_poly_reg);
    assign fb      = fp_ext[SW-1:0];
    assign root_x2 = root_reg[SW-1] ? ({root_reg[SW-2:0], 1'b0} ^ fb)
                                    : {root_reg[SW-2:0], 1'b0};

    assign ec_ext = EXW'(ec_count_reg);
    always_comb
    begin
        if (ec_ext == '0)
        begin
            n_act = NW'(1);
        end
        else if (ec_ext > EXW'(MAX_EC))
        begin
            n_act = NW'(MAX_EC);
        end
        else
        begin
            n_act = NW'(ec_ext);
        end
    end
    assign n_last = CNT_W'(n_act) - CNT_W'(1);

    // ---------------- control ----------------
    assign in_acc    = data_in.valid && data_in.ready;
    assign out_acc   = parity_out.valid && parity_out.ready;
    assign emit_last = (cnt_reg == n_last);
    assign fbk       = data_in.data_symbol ^ q_w[0];

    assign data_in.ready           = (state_reg == ST_RUN);
    assign parity_out.valid        = (state_reg == ST_EMIT);
    assign parity_out.parity_symbol = q_w[0];
    assign parity_out.last_parity  = emit_last;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        root_next  = root_reg;
        ctrl.op    = rspe_pkg::CELL_HOLD;
        bcast      = root_reg;
        case (state_reg)
            ST_INIT:
            begin
                ctrl.op    = rspe_pkg::CELL_CLEAR;
                root_next  = SW'(1);
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                // alpha^base by repeated doubling
                if (cnt_reg == CNT_W'(gen_base_reg))
                begin
                    cnt_next   = '0;
                    state_next = ST_POLY;
                end
                else
                begin
                    root_next = root_x2;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            ST_POLY:
            begin
                // multiply the generator by (x + root), one root per cycle
                ctrl.op   = rspe_pkg::CELL_BUILD;
                root_next = root_x2;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (emit_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                bcast = fbk;
                if (in_acc)
                begin
                    ctrl.op = rspe_pkg::CELL_STEP;
                    if (data_in.last_data)
                    begin
                        cnt_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // shifting out also leaves the chain zeroed for the next codeword
                if (out_acc)
                begin
                    ctrl.op  = rspe_pkg::CELL_SHIFT;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (emit_last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        if (cfg_hit)
        begin
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
    end

    // ---------------- chain of cells ----------------
    for (genvar j = 0; j < MAX_EC; j++)
    begin : g_cell
        logic [SW-1:0] h_left;
        logic [SW-1:0] q_right;

        if (j == 0)
        begin : g_first
            assign h_left = SW'(1);
        end
        else
        begin : g_mid
            assign h_left = h_w[j-1];
        end

        if (j == MAX_EC - 1)
        begin : g_end
            assign q_right = '0;
        end
        else
        begin : g_inner
            assign q_right = q_w[j+1];
        end

        rspe_cell #(
            .SYMBOL_BITS (SW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .fb      (fb),
            .bcast   (bcast),
            .h_left  (h_left),
            .q_right (q_right),
            .h_out   (h_w[j]),
            .q_out   (q_w[j])
        );
    end

endmodule

// ----- src/rspe_gfmul.sv -----
// Combinational GF(2^W) multiplier, shift-and-add with reduction by fb.
// No dependencies.
module rspe_gfmul #(
    parameter int W = 8
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] fb,
    output logic [W-1:0] p
);

    always_comb
    begin
        logic [W-1:0] acc;
        logic [W-1:0] sh;
        acc = '0;
        sh  = a;
        for (int i = 0; i < W; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ sh;
            end
            sh = sh[W-1] ? ({sh[W-2:0], 1'b0} ^ fb) : {sh[W-2:0], 1'b0};
        end
        p = acc;
    end

endmodule

// ----- src/rspe_cell.sv -----
// One cell of the encoder chain: a generator coefficient and a parity register.
// Depends on rspe_pkg and rspe_gfmul.
module rspe_cell #(
    parameter int SYMBOL_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rspe_pkg::cell_ctrl_t     ctrl,
    input  logic [SYMBOL_BITS-1:0]   fb,
    input  logic [SYMBOL_BITS-1:0]   bcast,
    input  logic [SYMBOL_BITS-1:0]   h_left,
    input  logic [SYMBOL_BITS-1:0]   q_right,
    output logic [SYMBOL_BITS-1:0]   h_out,
    output logic [SYMBOL_BITS-1:0]   q_out
);

    logic [SYMBOL_BITS-1:0] h_reg, h_next;
    logic [SYMBOL_BITS-1:0] q_reg, q_next;
    logic [SYMBOL_BITS-1:0] mul_b;
    logic [SYMBOL_BITS-1:0] prod;

    // Building multiplies the left neighbour by the root; stepping multiplies own coeff
    assign mul_b = (ctrl.op == rspe_pkg::CELL_BUILD) ? h_left : h_reg;

    rspe_gfmul #(
        .W (SYMBOL_BITS)
    ) u_mul (
        .a  (bcast),
        .b  (mul_b),
        .fb (fb),
        .p  (prod)
    );

    always_comb
    begin
        h_next = h_reg;
        q_next = q_reg;
        case (ctrl.op)
            rspe_pkg::CELL_CLEAR:
            begin
                h_next = '0;
                q_next = '0;
            end
            rspe_pkg::CELL_BUILD:
            begin
                h_next = h_reg ^ prod;
            end
            rspe_pkg::CELL_STEP:
            begin
                q_next = q_right ^ prod;
            end
            rspe_pkg::CELL_SHIFT:
            begin
                q_next = q_right;
            end
            default:
            begin
                h_next = h_reg;
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    // Coefficient is rebuilt after every reset, so it carries no reset
    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
    end

    assign h_out = h_reg;
    assign q_out = q_reg;

endmodule

// ----- tb/rspe_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the Reed-Solomon parity encoder: follows APB writes and both channels.
// Predicts the parity symbols of every codeword and compares them transaction by transaction.
// Depends on rspe_pkg, rspe_data_if and rspe_parity_if.
module rspe_checker #(
    parameter int MAX_EC = 30
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rspe_data_if                        data_ch,
    rspe_parity_if                      parity_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [rspe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output int                          outstanding,
    output int                          mismatches
);

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } parity_item_t;

    logic [rspe_pkg::FIELD_POLY_W-1:0] field_poly_q;
    logic [rspe_pkg::GEN_BASE_W-1:0]   gen_base_q;
    logic [rspe_pkg::EC_COUNT_W-1:0]   ec_count_q;

    logic [7:0]   gen_coef [MAX_EC];
    bit           gen_built;
    logic [7:0]   remainder [MAX_EC];
    parity_item_t expected_parity_q [$];

    // Multiply in GF(256); bit 8 of the polynomial is implied
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        logic       carry;
        int         i;
        acc = '0;
        x   = a;
        for (i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= x;
            carry = x[7];
            x     = x << 1;
            if (carry)
                x ^= field_poly_q[7:0];
        end
        return acc;
    endfunction

    function automatic int parity_width();
        if (ec_count_q == 0)
            return 1;
        if (ec_count_q > MAX_EC)
            return MAX_EC;
        return int'(ec_count_q);
    endfunction

    function automatic void clear_remainder();
        int j;
        for (j = 0; j < MAX_EC; j++)
            remainder[j] = '0;
    endfunction

    function automatic void build_generator();
        logic [7:0] poly [MAX_EC + 1];
        logic [7:0] root;
        int         n;
        int         i;
        int         k;
        n    = parity_width();
        root = 8'd1;
        // repeated doubling wraps a root exponent past the field order
        for (i = 0; i < int'(gen_base_q); i++)
            root = gf_times(root, 8'd2);
        for (k = 0; k <= MAX_EC; k++)
            poly[k] = '0;
        poly[0] = 8'd1;
        for (i = 0; i < n; i++)
        begin
            for (k = i + 1; k > 0; k--)
                poly[k] = poly[k - 1] ^ gf_times(root, poly[k]);
            poly[0] = gf_times(root, poly[0]);
            root    = gf_times(root, 8'd2);
        end
        for (k = 0; k < MAX_EC; k++)
            gen_coef[k] = (k < n) ? poly[k] : 8'd0;
        gen_built = 1'b1;
    endfunction

    function automatic void apply_write(input logic [rspe_pkg::ADDR_W-1:0] addr,
                                        input logic [31:0] value);
        case (addr[rspe_pkg::ADDR_W-1:2])
            rspe_pkg::REG_FIELD_POLY: field_poly_q = value[rspe_pkg::FIELD_POLY_W-1:0];
            rspe_pkg::REG_GEN_BASE:   gen_base_q   = value[rspe_pkg::GEN_BASE_W-1:0];
            rspe_pkg::REG_EC_COUNT:   ec_count_q   = value[rspe_pkg::EC_COUNT_W-1:0];
            default:                  return;
        endcase
        // any write to a mapped register forces a rebuild and abandons the codeword in progress
        gen_built = 1'b0;
        clear_remainder();
    endfunction

    function automatic void absorb_symbol(input logic [7:0] sym, input logic last);
        logic [7:0]   fbk;
        parity_item_t item;
        int           n;
        int           j;
        if (!gen_built)
            build_generator();
        n   = parity_width();
        fbk = sym ^ remainder[0];
        for (j = 0; j + 1 < n; j++)
            remainder[j] = remainder[j + 1] ^ gf_times(fbk, gen_coef[n - 1 - j]);
        remainder[n - 1] = gf_times(fbk, gen_coef[0]);
        if (last)
        begin
            for (j = 0; j < n; j++)
            begin
                item.symbol = remainder[j];
                item.last   = (j == n - 1);
                expected_parity_q = {expected_parity_q, item};
            end
            clear_remainder();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        parity_item_t want;
        if (!rst_n)
        begin
            field_poly_q = rspe_pkg::FIELD_POLY_RST;
            gen_base_q   = rspe_pkg::GEN_BASE_RST;
            ec_count_q   = rspe_pkg::EC_COUNT_RST;
            gen_built    = 1'b0;
            clear_remainder();
            expected_parity_q.delete();
            mismatches   = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr, pwdata);
            if (parity_ch.valid && parity_ch.ready)
            begin
                if (expected_parity_q.size() == 0)
                begin
                    $error("unexpected parity: parity_symbol %0h last_parity %0b",
                           parity_ch.parity_symbol, parity_ch.last_parity);
                    mismatches++;
                end
                else
                begin
                    want = expected_parity_q.pop_front();
                    if (parity_ch.parity_symbol !== want.symbol)
                    begin
                        $error("parity_symbol: expected %0h actual %0h",
                               want.symbol, parity_ch.parity_symbol);
                        mismatches++;
                    end
                    if (parity_ch.last_parity !== want.last)
                    begin
                        $error("last_parity: expected %0b actual %0b",
                               want.last, parity_ch.last_parity);
                        mismatches++;
                    end
                end
            end
            if (data_ch.valid && data_ch.ready)
                absorb_symbol(data_ch.data_symbol, data_ch.last_data);
        end
        outstanding = expected_parity_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the parity encoder testbench: clock, reset, APB writes and symbol stimulus, verdict.
// Depends on rspe_pkg, both channel interfaces, reed_solomon_parity_encoder and rspe_checker.
module tb_top;

    localparam int MAX_EC         = 30;
    localparam int RANDOM_SYMBOLS = 100;
    localparam int CALM_AFTER     = 80;

    logic                        clk   = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic                        pready;
    logic [rspe_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    int                          outstanding;
    int                          mismatches;
    int                          gap_pct     = 0;
    int                          stall_pct   = 0;
    int                          random_sent = 0;

    rspe_data_if   #(.SYMBOL_BITS(8)) data_ch ();
    rspe_parity_if #(.SYMBOL_BITS(8)) parity_ch ();

    reed_solomon_parity_encoder #(
        .MAX_EC      (MAX_EC),
        .SYMBOL_BITS (8)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_in    (data_ch),
        .parity_out (parity_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    rspe_checker #(
        .MAX_EC (MAX_EC)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_ch     (data_ch),
        .parity_ch   (parity_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Parity sink: stall in bursts with a chance of stall_pct percent
    initial
    begin
        parity_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                parity_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
                parity_ch.ready <= 1'b1;
        end
    end

    task automatic push_symbol(input logic [7:0] sym, input logic last);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            data_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        data_ch.valid       <= 1'b1;
        data_ch.data_symbol <= sym;
        data_ch.last_data   <= last;
        @(posedge clk);
        while (!data_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_word(input int len, input bit close);
        int i;
        for (i = 0; i < len; i++)
        begin
            push_symbol(8'($urandom_range(0, 255)), close && (i == len - 1));
            random_sent++;
        end
    endtask

    // Back-to-back writes keep psel high; the caller drops it
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_config(input logic [31:0] poly, input logic [31:0] base,
                               input logic [31:0] ec);
        data_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        // let an unfinished codeword settle before the write
        repeat (4) @(negedge clk);
        write_reg(rspe_pkg::REG_FIELD_POLY, poly);
        write_reg(rspe_pkg::REG_GEN_BASE, base);
        write_reg(rspe_pkg::REG_EC_COUNT, ec);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] poly;
        logic [31:0] base;
        int          len;
        data_ch.valid       = 1'b0;
        data_ch.data_symbol = '0;
        data_ch.last_data   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        gap_pct   = 30;
        stall_pct = 30;
        // reset configuration, single-symbol codewords at both extremes, then a three-symbol codeword
        push_symbol(8'h00, 1'b1);
        push_symbol(8'hFF, 1'b1);
        push_symbol(8'h01, 1'b0);
        push_symbol(8'h80, 1'b0);
        push_symbol(8'hFF, 1'b1);
        // zero parity count acts as one; root exponent past the field order
        load_config(285, 255, 0);
        push_symbol(8'h5A, 1'b0);
        push_symbol(8'hA5, 1'b1);
        // parity count above the maximum saturates
        load_config(285, 0, 31);
        push_symbol(8'hFF, 1'b0);
        push_symbol(8'h00, 1'b0);
        push_symbol(8'h33, 1'b1);
        load_config(511, 254, 30);
        push_symbol(8'hC3, 1'b1);
        // polynomial without its top bit
        load_config(29, 3, 4);
        push_symbol(8'h12, 1'b0);
        push_symbol(8'hFE, 1'b1);
        // non-primitive polynomial with no feedback
        load_config(256, 1, 7);
        push_symbol(8'h81, 1'b0);
        push_symbol(8'h7F, 1'b1);
        // abandon a codeword by a register write
        push_symbol(8'h44, 1'b0);
        push_symbol(8'h99, 1'b0);
        load_config(301, 0, 1);
        push_symbol(8'hE7, 1'b1);
        load_config(0, 7, 16);
        push_symbol(8'hAA, 1'b0);
        push_symbol(8'h55, 1'b1);

        while (random_sent < RANDOM_SYMBOLS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                case ($urandom_range(0, 7))
                    0:       poly = 285;
                    1:       poly = 299;
                    2:       poly = 301;
                    3:       poly = 333;
                    4:       poly = 351;
                    5:       poly = 355;
                    6:       poly = 357;
                    default: poly = 361;
                endcase
            end
            else
                poly = $urandom_range(0, 511);
            // keep most build times short
            base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
            load_config(poly, base, $urandom_range(0, 31));
            if (random_sent >= CALM_AFTER)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 25;
                    default: gap_pct = 60;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end
            repeat ($urandom_range(1, 4))
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
                send_random_word(len, 1'b1);
            end
            // now and then leave a codeword open for the next write to drop
            if ($urandom_range(0, 4) == 0)
                send_random_word($urandom_range(1, 3), 1'b0);
        end

        data_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rspe_pkg.sv
src/rspe_data_if.sv
src/rspe_parity_if.sv
src/rspe_gfmul.sv
src/rspe_cell.sv
src/reed_solomon_parity_encoder.sv
tb/rspe_checker.sv
tb/tb_top.sv
